### rtl/frq_pkg.sv
// Shared constants, codes and types of the FIFO run queue with remove.
`default_nettype none
package frq_pkg;

  // Number of slots, one cell each.
  localparam int unsigned QueueDepth = 16;
  // Identifier width; the stream ports carry 16-bit identifiers.
  localparam int unsigned IdWidth = 16;
  // Enough bits to hold the count itself, 0 to QueueDepth.
  localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

  typedef logic [IdWidth-1:0] id_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpDequeue = 2'd1,
    OpFind    = 2'd2,
    OpRemove  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StMiss = 2'd1,
    StFull = 2'd2
  } status_e;

  // Commands broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic deq;  // every cell takes its upper neighbor's identifier
    logic rem;  // cells at and above the first match take their neighbor's identifier
    logic enq;  // the cell at the tail position loads the key
    id_t  key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/fifo_run_queue_with_remove_unit.sv
// Top level of the FIFO run queue with enqueue, dequeue, find and remove by identifier.
//
//  Channel   Direction  tdata (low bit up)            tuser
//  s_axis    in         thread_id[15:0]               opcode[1:0]
//  m_axis    out        out_id[15:0], occupancy[20:16] status[1:0]
//
// One beat is accepted per cycle and its result appears in the output register on the
// next cycle. The critical path is the match chain that ripples from the head cell to the
// tail cell, one comparator and one OR per cell. Reset clears the entry count and the
// output valid flag; slot contents need no clearing, since a slot beyond the count is never read.
// While a result waits in the output register, a new beat is taken only in the cycle in
// which that result is taken.
`default_nettype none
module fifo_run_queue_with_remove_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // thread_id[15:0]
  input  wire logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // out_id[15:0], occupancy[20:16], zeros
  output logic [1:0]       m_axis_tuser_o    // status[1:0]
);

  localparam int unsigned Depth = frq_pkg::QueueDepth;

  frq_pkg::count_t    count_q, count_d;
  logic               out_valid_q;
  frq_pkg::id_t       out_id_q, out_id_d;
  frq_pkg::status_e   status_q, status_d;
  logic [4:0]         occ_q;

  frq_pkg::op_e       op;
  frq_pkg::id_t       key;
  logic               in_fire;
  logic               full, empty, found;
  frq_pkg::cell_ctrl_t ctrl;

  // Cell outputs and the neighbor links; seen[Depth] is the match flag of the whole row.
  frq_pkg::id_t       cell_id [Depth];
  frq_pkg::id_t       next_id [Depth];
  logic [Depth:0]     seen;
  logic [Depth-1:0]   occupied, tail;

  // The output register is the only buffer: accept when it is empty or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign op    = frq_pkg::op_e'(s_axis_tuser_i);
  assign key   = frq_pkg::id_t'(s_axis_tdata_i);
  assign full  = (count_q == frq_pkg::count_t'(Depth));
  assign empty = (count_q == '0);
  assign found = seen[Depth];

  // Commands go to the cells only with an accepted beat, so a stall never moves data.
  always_comb begin
    ctrl.key = key;
    ctrl.enq = in_fire && (op == frq_pkg::OpEnqueue) && !full;
    ctrl.deq = in_fire && (op == frq_pkg::OpDequeue) && !empty;
    ctrl.rem = in_fire && (op == frq_pkg::OpRemove);
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    // Occupancy and tail position come from the count as a thermometer and a one-hot (all zero when full).
    assign occupied[i] = (frq_pkg::count_t'(i) < count_q);
    assign tail[i]     = (frq_pkg::count_t'(i) == count_q);

    if (i == Depth - 1) begin : g_last
      // The top cell has no upper neighbor; what it takes then lies past the count.
      assign next_id[i] = '0;
    end else begin : g_mid
      assign next_id[i] = cell_id[i+1];
    end

    frq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occupied[i]),
      .tail_i     (tail[i]),
      .seen_i     (seen[i]),
      .next_id_i  (next_id[i]),
      .id_o       (cell_id[i]),
      .seen_o     (seen[i+1])
    );
  end

  // Result and new count for the beat that is accepted in this cycle.
  always_comb begin
    count_d  = count_q;
    status_d = frq_pkg::StMiss;
    out_id_d = '0;
    case (op)
      frq_pkg::OpEnqueue: begin
        if (full) begin
          status_d = frq_pkg::StFull;
        end else begin
          status_d = frq_pkg::StOk;
          out_id_d = key;
          count_d  = count_q + 1'b1;
        end
      end
      frq_pkg::OpDequeue: begin
        if (!empty) begin
          status_d = frq_pkg::StOk;
          out_id_d = cell_id[0];
          count_d  = count_q - 1'b1;
        end
      end
      frq_pkg::OpFind: begin
        if (found) begin
          status_d = frq_pkg::StOk;
          out_id_d = key;
        end
      end
      frq_pkg::OpRemove: begin
        if (found) begin
          status_d = frq_pkg::StOk;
          out_id_d = key;
          count_d  = count_q - 1'b1;
        end
      end
      default: begin
        status_d = frq_pkg::StMiss;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the result register; loaded with every accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_id_q <= out_id_d;
      status_q <= status_d;
      occ_q    <= 5'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, occ_q, 16'(out_id_q)};
  assign m_axis_tuser_o  = status_q;

endmodule
`default_nettype wire

### rtl/frq_cell.sv
// One queue slot: holds an identifier, compares it and shifts toward the head.
`default_nettype none
module frq_cell (
  input  wire logic                clk_i,
  input  wire frq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occupied_i,
  input  wire logic                tail_i,
  input  wire logic                seen_i,
  input  wire frq_pkg::id_t        next_id_i,
  output frq_pkg::id_t             id_o,
  output logic                     seen_o
);

  frq_pkg::id_t id_q, id_d;
  logic         hit;

  // A match counts only in an occupied slot; seen ripples up from the head.
  assign hit    = occupied_i && (id_q == ctrl_i.key);
  assign seen_o = seen_i || hit;
  assign id_o   = id_q;

  always_comb begin
    id_d = id_q;
    if (ctrl_i.deq || (ctrl_i.rem && seen_o)) begin
      id_d = next_id_i;
    end else if (ctrl_i.enq && tail_i) begin
      id_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule
`default_nettype wire

### rtl/frq_checker.sv
// Port-level checker of the FIFO run queue, bound to the top level.
`default_nettype none
module frq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_i,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_i,
  input wire logic [1:0]  m_axis_tuser_i
);

  // A dropped enqueue is reported only when the queue is at its full depth.
  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tuser_i == frq_pkg::StFull) |->
      (m_axis_tdata_i[20:16] == 5'(frq_pkg::QueueDepth)))
    else $error("full status reported below full depth");

  // Any result other than done carries a zero identifier.
  a_miss_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && m_axis_tuser_i != frq_pkg::StOk) |-> (m_axis_tdata_i[15:0] == '0))
    else $error("identifier not zero on a failed operation");

  // Occupancy never exceeds the depth and the padding bits stay zero.
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |->
      (m_axis_tdata_i[20:16] <= 5'(frq_pkg::QueueDepth) && m_axis_tdata_i[23:21] == 3'b000))
    else $error("occupancy out of range");

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=>
      (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i)))
    else $error("stalled result changed");

endmodule

bind fifo_run_queue_with_remove_unit frq_checker u_frq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
`default_nettype wire
